FILE: rtl/jhmp_pkg.sv
// shared types and constants of the jpeg header marker parser
package jhmp_pkg;

    localparam int MaxFrameComponents = 3;
    localparam int MaxHuffSymbols     = 256;
    localparam int QueueDepth         = 2;

    // item kinds
    localparam logic [3:0] K_QUANT     = 4'd0;
    localparam logic [3:0] K_HUFFCOUNT = 4'd1;
    localparam logic [3:0] K_HUFFSYM   = 4'd2;
    localparam logic [3:0] K_HEIGHT    = 4'd3;
    localparam logic [3:0] K_WIDTH     = 4'd4;
    localparam logic [3:0] K_FRAMECOMP = 4'd5;
    localparam logic [3:0] K_SCANCOMP  = 4'd6;
    localparam logic [3:0] K_SS        = 4'd7;
    localparam logic [3:0] K_SE        = 4'd8;
    localparam logic [3:0] K_AHAL      = 4'd9;
    localparam logic [3:0] K_COMMENT   = 4'd10;
    localparam logic [3:0] K_DATA      = 4'd11;
    localparam logic [3:0] K_END       = 4'd12;
    localparam logic [3:0] K_ERROR     = 4'd13;

    // error codes
    localparam logic [3:0] E_SOI     = 4'd0;
    localparam logic [3:0] E_MARKER  = 4'd1;
    localparam logic [3:0] E_APP_SIG = 4'd2;
    localparam logic [3:0] E_DQT_ID  = 4'd3;
    localparam logic [3:0] E_PREC    = 4'd4;
    localparam logic [3:0] E_COMPS   = 4'd5;
    localparam logic [3:0] E_SOF_LEN = 4'd6;
    localparam logic [3:0] E_DHT_BIT = 4'd7;
    localparam logic [3:0] E_DHT_ID  = 4'd8;
    localparam logic [3:0] E_SYMBOLS = 4'd9;
    localparam logic [3:0] E_SOS_LEN = 4'd10;

    // marker codes
    localparam logic [7:0] M_PREFIX = 8'hFF;
    localparam logic [7:0] M_SOI    = 8'hD8;
    localparam logic [7:0] M_EOI    = 8'hD9;
    localparam logic [7:0] M_APP0   = 8'hE0;
    localparam logic [7:0] M_COM    = 8'hFE;
    localparam logic [7:0] M_DQT    = 8'hDB;
    localparam logic [7:0] M_SOF0   = 8'hC0;
    localparam logic [7:0] M_DHT    = 8'hC4;
    localparam logic [7:0] M_SOS    = 8'hDA;

    localparam logic [7:0] DqtEntries = 8'd64;

    typedef struct packed {
        logic [3:0]  item_kind;
        logic        table_class;
        logic [7:0]  table_sel;
        logic [7:0]  entry_index;
        logic [15:0] item_value;
        logic [3:0]  horiz_samp;
        logic [3:0]  vert_samp;
        logic [3:0]  dc_table;
        logic [3:0]  ac_table;
        logic [3:0]  error_code;
    } t_result;

    // jfif signature byte by position
    function automatic logic [7:0] jfif_sig(input logic [2:0] idx);
        logic [7:0] v;
        begin
            case (idx)
                3'd0: v = 8'h4A;
                3'd1: v = 8'h46;
                3'd2: v = 8'h49;
                3'd3: v = 8'h46;
                3'd4: v = 8'h00;
                3'd5: v = 8'h01;
                default: v = 8'h01;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: rtl/jhmp_if.sv
// valid/ready channel interfaces for bytes and result items
interface jhmp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface jhmp_result_if;
    logic              valid;
    logic              ready;
    jhmp_pkg::t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/jpeg_header_marker_parser.sv
// top level: jpeg header marker parser
// path: each byte passes the front queue and then the result register in the back stage (data bytes one byte later)
// throughput: one byte per cycle while the receiver is ready, limited by the single-byte parse step in the back stage
// front queue of two bytes decouples input from the parser and result register
// synchronous active-low reset returns to waiting for the start-of-image marker
// after an error or end item the block drops all further bytes until reset
module jpeg_header_marker_parser #(
    parameter int MAX_FRAME_COMPONENTS = jhmp_pkg::MaxFrameComponents,
    parameter int MAX_HUFF_SYMBOLS     = jhmp_pkg::MaxHuffSymbols
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    jhmp_byte_if.sink     i_in,
    jhmp_result_if.source o_out
);
    jhmp_byte_if q_if ();

    // byte queue
    jhmp_front #(.DEPTH(jhmp_pkg::QueueDepth)) u_front (
        .i_clk, .i_rst_n, .i_in(i_in), .o_out(q_if.source)
    );

    // parser
    jhmp_back #(
        .MAX_FRAME_COMPONENTS(MAX_FRAME_COMPONENTS),
        .MAX_HUFF_SYMBOLS(MAX_HUFF_SYMBOLS)
    ) u_back (
        .i_clk, .i_rst_n, .i_in(q_if.sink), .o_out(o_out)
    );

    // kind stays in the defined range
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.payload.item_kind <= jhmp_pkg::K_ERROR))
        else $error("kind out of range");

    // error code only on error items
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.item_kind != jhmp_pkg::K_ERROR)
            |-> (o_out.payload.error_code == 4'd0))
        else $error("stray error code");

    // a held result stays until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.payload)))
        else $error("result dropped");
endmodule

FILE: rtl/jhmp_front.sv
// front stage: accepts bytes into a short queue
module jhmp_front #(
    parameter int DEPTH = jhmp_pkg::QueueDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jhmp_byte_if.sink  i_in,
    jhmp_byte_if.source o_out
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;
    logic push, pop;

    assign i_in.ready      = (r_cnt != (AW+1)'(DEPTH));
    assign o_out.valid     = (r_cnt != '0);
    assign o_out.data_byte = r_mem[r_rp];
    assign push = i_in.valid & i_in.ready;
    assign pop  = o_out.valid & o_out.ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_in.data_byte;
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

FILE: rtl/jhmp_back.sv
// back stage: marker and segment parser with a result register
module jhmp_back #(
    parameter int MAX_FRAME_COMPONENTS = jhmp_pkg::MaxFrameComponents,
    parameter int MAX_HUFF_SYMBOLS     = jhmp_pkg::MaxHuffSymbols
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    jhmp_byte_if.sink     i_in,
    jhmp_result_if.source o_out
);
    typedef enum logic [5:0] {
        PH_SOI0, PH_SOI1, PH_MARK0, PH_MARK1,
        PH_LEN_HI, PH_LEN_LO,
        PH_APP_SIG, PH_APP_SKIP, PH_COM, PH_DQT_HDR, PH_DQT_ENT, PH_DQT_LO,
        PH_SOF_P, PH_SOF_H0, PH_SOF_H1, PH_SOF_W0, PH_SOF_W1, PH_SOF_N,
        PH_SOF_CID, PH_SOF_HV, PH_SOF_TQ, PH_DHT_HDR, PH_DHT_CNT, PH_DHT_SYM,
        PH_SOS_N, PH_SOS_CID, PH_SOS_TT, PH_SOS_SS, PH_SOS_SE, PH_SOS_A,
        PH_DATA
    } t_phase;

    typedef enum logic [2:0] {
        SEG_APP, SEG_COM, SEG_DQT, SEG_SOF, SEG_DHT, SEG_SOS
    } t_seg;

    t_phase r_phase, n_phase;
    t_seg   r_seg, n_seg;
    logic [15:0] r_len, n_len, r_pos, n_pos;
    logic [7:0]  r_cnt, n_cnt, r_hold, n_hold, r_ncomp, n_ncomp;
    logic [7:0]  r_base, n_base, r_cid, n_cid, r_held, n_held;
    logic [3:0]  r_tid, n_tid;
    logic        r_cls, n_cls, r_prec, n_prec, r_hv, n_hv, r_halt, n_halt;
    logic [11:0] r_tot, n_tot;
    logic        r_ov, n_ov;
    jhmp_pkg::t_result r_res, n_res;

    logic [7:0]  b;
    logic        take, emit;
    logic [15:0] pos_i;
    logic [11:0] tot_sum;
    logic        at_end;

    // ready whenever the result register is free or leaving
    assign i_in.ready    = !r_ov || o_out.ready;
    assign take          = i_in.valid && i_in.ready;
    assign o_out.valid   = r_ov;
    assign o_out.payload = r_res;
    assign b = i_in.data_byte;

    // position advances inside segments, saturating
    always_comb begin
        pos_i = r_pos;
        if (r_phase >= PH_APP_SIG && r_phase < PH_DATA && r_pos != 16'hFFFF)
            pos_i = r_pos + 16'd1;
        at_end  = (pos_i >= r_len);
        tot_sum = r_tot + {4'd0, b};
    end

    // next-state parse logic
    always_comb begin
        n_phase = r_phase; n_seg = r_seg; n_len = r_len; n_pos = r_pos;
        n_cnt = r_cnt; n_hold = r_hold; n_ncomp = r_ncomp; n_base = r_base;
        n_cid = r_cid; n_held = r_held; n_tid = r_tid; n_cls = r_cls;
        n_prec = r_prec; n_hv = r_hv; n_halt = r_halt; n_tot = r_tot;
        n_res = '0;
        emit = 1'b0;
        if (!r_halt) begin
            n_pos = pos_i;
            unique case (r_phase)
                PH_SOI0: begin
                    if (b != jhmp_pkg::M_PREFIX) begin
                        emit = 1'b1; n_halt = 1'b1;
                        n_res.item_kind = jhmp_pkg::K_ERROR;
                        n_res.error_code = jhmp_pkg::E_SOI;
                    end else n_phase = PH_SOI1;
                end
                PH_SOI1: begin
                    if (b != jhmp_pkg::M_SOI) begin
                        emit = 1'b1; n_halt = 1'b1;
                        n_res.item_kind = jhmp_pkg::K_ERROR;
                        n_res.error_code = jhmp_pkg::E_SOI;
                    end else n_phase = PH_MARK0;
                end
                PH_MARK0: begin
                    if (b != jhmp_pkg::M_PREFIX) begin
                        emit = 1'b1; n_halt = 1'b1;
                        n_res.item_kind = jhmp_pkg::K_ERROR;
                        n_res.error_code = jhmp_pkg::E_MARKER;
                    end else n_phase = PH_MARK1;
                end
                PH_MARK1: begin
                    n_phase = PH_LEN_HI;
                    unique case (b)
                        jhmp_pkg::M_APP0: n_seg = SEG_APP;
                        jhmp_pkg::M_COM:  n_seg = SEG_COM;
                        jhmp_pkg::M_DQT:  n_seg = SEG_DQT;
                        jhmp_pkg::M_SOF0: n_seg = SEG_SOF;
                        jhmp_pkg::M_DHT:  n_seg = SEG_DHT;
                        jhmp_pkg::M_SOS:  n_seg = SEG_SOS;
                        jhmp_pkg::M_EOI: begin
                            emit = 1'b1; n_halt = 1'b1;
                            n_res.item_kind = jhmp_pkg::K_END;
                        end
                        default: begin
                            emit = 1'b1; n_halt = 1'b1;
                            n_res.item_kind = jhmp_pkg::K_ERROR;
                            n_res.error_code = jhmp_pkg::E_MARKER;
                        end
                    endcase
                end
                PH_LEN_HI: begin
                    n_len = {b, 8'd0};
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len = {r_len[15:8], b};
                    n_pos = 16'd2;
                    n_cnt = '0;
                    unique case (r_seg)
                        SEG_APP: n_phase = PH_APP_SIG;
                        SEG_COM: n_phase = (16'd2 >= n_len) ? PH_MARK0 : PH_COM;
                        SEG_DQT: n_phase = (16'd2 >= n_len) ? PH_MARK0 : PH_DQT_HDR;
                        SEG_SOF: n_phase = PH_SOF_P;
                        SEG_DHT: n_phase = (16'd2 >= n_len) ? PH_MARK0 : PH_DHT_HDR;
                        default: n_phase = PH_SOS_N;
                    endcase
                end
                PH_APP_SIG: begin
                    if (r_cnt > 8'd6 || b != jhmp_pkg::jfif_sig(r_cnt[2:0])) begin
                        emit = 1'b1; n_halt = 1'b1;
                        n_res.item_kind = jhmp_pkg::K_ERROR;
                        n_res.error_code = jhmp_pkg::E_APP_SIG;
                    end else begin
                        n_cnt = r_cnt + 8'd1;
                        if (r_cnt == 8'd6) n_phase = at_end ? PH_MARK0 : PH_APP_SKIP;
                    end
                end
                PH_APP_SKIP: n_phase = at_end ? PH_MARK0 : PH_APP_SKIP;
                PH_COM: begin
                    emit = 1'b1;
                    n_res.item_kind = jhmp_pkg::K_COMMENT;
                    n_res.entry_index = r_cnt;
                    n_res.item_value = {8'd0, b};
                    n_cnt = r_cnt + 8'd1;
                    n_phase = at_end ? PH_MARK0 : PH_COM;
                end
                PH_DQT_HDR: begin
                    if (b[3:0] > 4'd3) begin
                        emit = 1'b1; n_halt = 1'b1;
                        n_res.item_kind = jhmp_pkg::K_ERROR;
                        n_res.error_code = jhmp_pkg::E_DQT_ID;
                    end else begin
                        n_tid = b[3:0];
                        n_prec = (b[7:4] != 4'd0);
                        n_cnt = '0;
                        n_phase = PH_DQT_ENT;
                    end
                end
                PH_DQT_ENT, PH_DQT_LO: begin
                    if (r_phase == PH_DQT_ENT && r_prec) begin
                        n_hold = b;
                        n_phase = PH_DQT_LO;
                    end else begin
                        emit = 1'b1;
                        n_res.item_kind = jhmp_pkg::K_QUANT;
                        n_res.table_sel = {4'd0, r_tid};
                        n_res.entry_index = r_cnt;
                        n_res.item_value = (r_phase == PH_DQT_LO) ? {r_hold, b}
                                                                   : {8'd0, b};
                        n_cnt = r_cnt + 8'd1;
                        if (n_cnt >= jhmp_pkg::DqtEntries)
                            n_phase = at_end ? PH_MARK0 : PH_DQT_HDR;
                        else n_phase = PH_DQT_ENT;
                    end
                end
                PH_SOF_P: begin
                    if (b != 8'd8) begin
                        emit = 1'b1; n_halt = 1'b1;
                        n_res.item_kind = jhmp_pkg::K_ERROR;
                        n_res.error_code = jhmp_pkg::E_PREC;
                    end else n_phase = PH_SOF_H0;
                end
                PH_SOF_H0: begin n_hold = b; n_phase = PH_SOF_H1; end
                PH_SOF_W0: begin n_hold = b; n_phase = PH_SOF_W1; end
                PH_SOF_H1, PH_SOF_W1: begin
                    emit = 1'b1;
                    n_res.item_kind = (r_phase == PH_SOF_H1) ? jhmp_pkg::K_HEIGHT
                                                             : jhmp_pkg::K_WIDTH;
                    n_res.item_value = {r_hold, b};
                    n_phase = (r_phase == PH_SOF_H1) ? PH_SOF_W0 : PH_SOF_N;
                end
                PH_SOF_N: begin
                    if (b > 8'(MAX_FRAME_COMPONENTS)) begin
                        emit = 1'b1; n_halt = 1'b1;
                        n_res.item_kind = jhmp_pkg::K_ERROR;
                        n_res.error_code = jhmp_pkg::E_COMPS;
                    end else if (r_len != 16'd8 + 16'd3 * {8'd0, b}) begin
                        emit = 1'b1; n_halt = 1'b1;
                        n_res.item_kind = jhmp_pkg::K_ERROR;
                        n_res.error_code = jhmp_pkg::E_SOF_LEN;
                    end else begin
                        n_ncomp = b;
                        n_cnt = '0;
                        n_phase = (b == 8'd0) ? PH_MARK0 : PH_SOF_CID;
                    end
                end
                PH_SOF_CID: begin n_cid = b; n_phase = PH_SOF_HV; end
                PH_SOF_HV:  begin n_hold = b; n_phase = PH_SOF_TQ; end
                PH_SOF_TQ: begin
                    emit = 1'b1;
                    n_res.item_kind = jhmp_pkg::K_FRAMECOMP;
                    n_res.table_sel = b;
                    n_res.entry_index = r_cnt;
                    n_res.item_value = {8'd0, r_cid};
                    n_res.horiz_samp = r_hold[7:4];
                    n_res.vert_samp = r_hold[3:0];
                    n_cnt = r_cnt + 8'd1;
                    n_phase = (n_cnt >= r_ncomp) ? PH_MARK0 : PH_SOF_CID;
                end
                PH_DHT_HDR: begin
                    if (b[7:5] != 3'd0) begin
                        emit = 1'b1; n_halt = 1'b1;
                        n_res.item_kind = jhmp_pkg::K_ERROR;
                        n_res.error_code = jhmp_pkg::E_DHT_BIT;
                    end else if (b[3:0] > 4'd3) begin
                        emit = 1'b1; n_halt = 1'b1;
                        n_res.item_kind = jhmp_pkg::K_ERROR;
                        n_res.error_code = jhmp_pkg::E_DHT_ID;
                    end else begin
                        n_cls = b[4];
                        n_tid = b[3:0];
                        n_cnt = '0;
                        n_tot = '0;
                        n_phase = PH_DHT_CNT;
                    end
                end
                PH_DHT_CNT: begin
                    n_tot = tot_sum;
                    emit = 1'b1;
                    n_res.item_kind = jhmp_pkg::K_HUFFCOUNT;
                    n_res.table_class = r_cls;
                    n_res.table_sel = {4'd0, r_tid};
                    n_res.entry_index = r_cnt;
                    n_res.item_value = {8'd0, b};
                    n_cnt = (r_cnt == 8'd15) ? 8'd0 : r_cnt + 8'd1;
                    if (r_cnt == 8'd15) begin
                        if (tot_sum > 12'(MAX_HUFF_SYMBOLS)) begin
                            n_halt = 1'b1;
                            n_res = '0;
                            n_res.item_kind = jhmp_pkg::K_ERROR;
                            n_res.error_code = jhmp_pkg::E_SYMBOLS;
                            n_cnt = r_cnt;
                        end else if (tot_sum == 12'd0)
                            n_phase = at_end ? PH_MARK0 : PH_DHT_HDR;
                        else n_phase = PH_DHT_SYM;
                    end
                end
                PH_DHT_SYM: begin
                    emit = 1'b1;
                    n_res.item_kind = jhmp_pkg::K_HUFFSYM;
                    n_res.table_class = r_cls;
                    n_res.table_sel = {4'd0, r_tid};
                    n_res.entry_index = r_cnt;
                    n_res.item_value = {8'd0, b};
                    n_cnt = r_cnt + 8'd1;
                    n_tot = r_tot - 12'd1;
                    if (r_tot == 12'd1) n_phase = at_end ? PH_MARK0 : PH_DHT_HDR;
                end
                PH_SOS_N: begin
                    if (r_len != 16'd6 + {7'd0, b, 1'b0}) begin
                        emit = 1'b1; n_halt = 1'b1;
                        n_res.item_kind = jhmp_pkg::K_ERROR;
                        n_res.error_code = jhmp_pkg::E_SOS_LEN;
                    end else begin
                        n_cnt = b;
                        n_phase = (b == 8'd0) ? PH_SOS_SS : PH_SOS_CID;
                    end
                end
                PH_SOS_CID: begin n_cid = b; n_phase = PH_SOS_TT; end
                PH_SOS_TT: begin
                    emit = 1'b1;
                    n_res.item_kind = jhmp_pkg::K_SCANCOMP;
                    n_res.entry_index = r_base;
                    n_res.item_value = {8'd0, r_cid};
                    n_res.dc_table = b[7:4];
                    n_res.ac_table = b[3:0];
                    n_base = r_base + 8'd1;
                    n_cnt = r_cnt - 8'd1;
                    n_phase = (r_cnt == 8'd1) ? PH_SOS_SS : PH_SOS_CID;
                end
                PH_SOS_SS, PH_SOS_SE: begin
                    emit = 1'b1;
                    n_res.item_kind = (r_phase == PH_SOS_SS) ? jhmp_pkg::K_SS
                                                             : jhmp_pkg::K_SE;
                    n_res.item_value = {8'd0, b};
                    n_phase = (r_phase == PH_SOS_SS) ? PH_SOS_SE : PH_SOS_A;
                end
                PH_SOS_A: begin
                    emit = 1'b1;
                    n_res.item_kind = jhmp_pkg::K_AHAL;
                    n_res.item_value = {8'd0, b};
                    n_hv = 1'b0;
                    n_phase = PH_DATA;
                end
                PH_DATA: begin
                    if (r_hv && r_held == jhmp_pkg::M_PREFIX && b == jhmp_pkg::M_EOI) begin
                        emit = 1'b1; n_halt = 1'b1;
                        n_res.item_kind = jhmp_pkg::K_END;
                    end else begin
                        emit = r_hv;
                        n_res.item_kind = jhmp_pkg::K_DATA;
                        n_res.item_value = {8'd0, r_held};
                        n_held = b;
                        n_hv = 1'b1;
                    end
                end
                default: begin
                    emit = 1'b1; n_halt = 1'b1;
                    n_res.item_kind = jhmp_pkg::K_ERROR;
                    n_res.error_code = jhmp_pkg::E_MARKER;
                end
            endcase
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SOI0; r_seg <= SEG_APP; r_len <= '0; r_pos <= '0;
            r_cnt <= '0; r_hold <= '0; r_ncomp <= '0; r_base <= '0; r_cid <= '0;
            r_held <= '0; r_tid <= '0; r_cls <= 1'b0; r_prec <= 1'b0;
            r_hv <= 1'b0; r_halt <= 1'b0; r_tot <= '0; r_ov <= 1'b0;
        end else begin
            if (o_out.ready) r_ov <= 1'b0;
            if (take) begin
                r_phase <= n_phase; r_seg <= n_seg; r_len <= n_len; r_pos <= n_pos;
                r_cnt <= n_cnt; r_hold <= n_hold; r_ncomp <= n_ncomp;
                r_base <= n_base; r_cid <= n_cid; r_held <= n_held; r_tid <= n_tid;
                r_cls <= n_cls; r_prec <= n_prec; r_hv <= n_hv; r_halt <= n_halt;
                r_tot <= n_tot;
                if (emit) begin
                    r_ov <= 1'b1;
                    r_res <= n_res;
                end
            end
        end
    end
endmodule

FILE: verif/jpeg_header_marker_parser_tb.sv
// testbench: random and directed jpeg header streams checked against a byte-level predictor
module jpeg_header_marker_parser_tb;

    localparam int CycleLimit = 400000;
    localparam int HoldCycles = 120;

    typedef enum int {
        P_SOI0, P_SOI1, P_MARK0, P_MARK1,
        P_LEN_HI, P_LEN_LO,
        P_APP_SIG, P_APP_SKIP, P_COM, P_DQT_HDR, P_DQT_ENT, P_DQT_LO,
        P_SOF_P, P_SOF_H0, P_SOF_H1, P_SOF_W0, P_SOF_W1, P_SOF_N,
        P_SOF_CID, P_SOF_HV, P_SOF_TQ,
        P_DHT_HDR, P_DHT_CNT, P_DHT_SYM,
        P_SOS_N, P_SOS_CID, P_SOS_TT, P_SOS_SS, P_SOS_SE, P_SOS_A, P_DATA
    } t_phase;

    typedef enum int { S_APP0, S_COM, S_DQT, S_SOF, S_DHT, S_SOS } t_segment;

    // parse model and store of expected result items
    class marker_scoreboard;
        jhmp_pkg::t_result pending[$];
        t_phase      phase;
        t_segment    seg;
        logic [15:0] seg_len;
        logic [15:0] seg_pos;
        logic [7:0]  cnt;
        logic [3:0]  tid;
        logic        cls;
        logic        wide;
        logic [7:0]  hold;
        logic [11:0] sym_total;
        logic [7:0]  ncomp;
        logic [7:0]  scan_base;
        logic [7:0]  cid;
        logic [7:0]  held;
        logic        held_v;
        logic        halted;
        int          n_checked;

        function new();
            phase = P_SOI0; seg = S_APP0;
            seg_len = '0; seg_pos = '0; cnt = '0; tid = '0; cls = 0; wide = 0;
            hold = '0; sym_total = '0; ncomp = '0; scan_base = '0; cid = '0;
            held = '0; held_v = 0; halted = 0; n_checked = 0;
        endfunction

        function t_phase past_table(t_phase nxt);
            return (seg_pos >= seg_len) ? P_MARK0 : nxt;
        endfunction

        function void push(logic [3:0] kind, logic c, logic [7:0] sel, logic [7:0] idx,
                           logic [15:0] val);
            jhmp_pkg::t_result r;
            r = '0;
            r.item_kind = kind; r.table_class = c; r.table_sel = sel;
            r.entry_index = idx; r.item_value = val;
            pending.push_back(r);
        endfunction

        function void error_out(logic [3:0] code);
            jhmp_pkg::t_result r;
            r = '0;
            r.item_kind = jhmp_pkg::K_ERROR; r.error_code = code;
            pending.push_back(r);
            halted = 1;
        endfunction

        function logic [7:0] sig_byte(logic [7:0] i);
            case (i)
                8'd0: return 8'h4A;
                8'd1: return 8'h46;
                8'd2: return 8'h49;
                8'd3: return 8'h46;
                8'd4: return 8'h00;
                default: return 8'h01;
            endcase
        endfunction

        // one accepted byte
        function void note_byte(logic [7:0] b);
            jhmp_pkg::t_result r;
            if (halted) return;
            if (phase >= P_APP_SIG && phase < P_DATA && seg_pos != 16'hFFFF) seg_pos++;
            case (phase)
                P_SOI0: if (b != jhmp_pkg::M_PREFIX) error_out(jhmp_pkg::E_SOI);
                        else phase = P_SOI1;
                P_SOI1: if (b != jhmp_pkg::M_SOI) error_out(jhmp_pkg::E_SOI);
                        else phase = P_MARK0;
                P_MARK0: if (b != jhmp_pkg::M_PREFIX) error_out(jhmp_pkg::E_MARKER);
                         else phase = P_MARK1;
                P_MARK1: begin
                    phase = P_LEN_HI;
                    case (b)
                        jhmp_pkg::M_APP0: seg = S_APP0;
                        jhmp_pkg::M_COM:  seg = S_COM;
                        jhmp_pkg::M_DQT:  seg = S_DQT;
                        jhmp_pkg::M_SOF0: seg = S_SOF;
                        jhmp_pkg::M_DHT:  seg = S_DHT;
                        jhmp_pkg::M_SOS:  seg = S_SOS;
                        jhmp_pkg::M_EOI: begin
                            push(jhmp_pkg::K_END, 0, 0, 0, 0);
                            halted = 1;
                        end
                        default: error_out(jhmp_pkg::E_MARKER);
                    endcase
                end
                P_LEN_HI: begin
                    seg_len = {b, 8'h00};
                    phase = P_LEN_LO;
                end
                P_LEN_LO: begin
                    seg_len[7:0] = b;
                    seg_pos = 16'd2;
                    cnt = '0;
                    case (seg)
                        S_APP0: phase = P_APP_SIG;
                        S_COM:  phase = past_table(P_COM);
                        S_DQT:  phase = past_table(P_DQT_HDR);
                        S_SOF:  phase = P_SOF_P;
                        S_DHT:  phase = past_table(P_DHT_HDR);
                        default: phase = P_SOS_N;
                    endcase
                end
                P_APP_SIG: begin
                    if (cnt > 6 || b != sig_byte(cnt)) error_out(jhmp_pkg::E_APP_SIG);
                    else begin
                        cnt++;
                        if (cnt == 7) phase = past_table(P_APP_SKIP);
                    end
                end
                P_APP_SKIP: phase = past_table(P_APP_SKIP);
                P_COM: begin
                    push(jhmp_pkg::K_COMMENT, 0, 0, cnt, {8'h00, b});
                    cnt++;
                    phase = past_table(P_COM);
                end
                P_DQT_HDR: begin
                    if (b[3:0] > 3) error_out(jhmp_pkg::E_DQT_ID);
                    else begin
                        tid = b[3:0];
                        wide = (b[7:4] != 0);
                        cnt = '0;
                        phase = P_DQT_ENT;
                    end
                end
                P_DQT_ENT, P_DQT_LO: begin
                    if (phase == P_DQT_ENT && wide) begin
                        hold = b;
                        phase = P_DQT_LO;
                    end else begin
                        push(jhmp_pkg::K_QUANT, 0, {4'h0, tid}, cnt,
                             phase == P_DQT_LO ? {hold, b} : {8'h00, b});
                        cnt++;
                        phase = (cnt >= jhmp_pkg::DqtEntries) ? past_table(P_DQT_HDR)
                                                              : P_DQT_ENT;
                    end
                end
                P_SOF_P: if (b != 8'd8) error_out(jhmp_pkg::E_PREC); else phase = P_SOF_H0;
                P_SOF_H0: begin hold = b; phase = P_SOF_H1; end
                P_SOF_W0: begin hold = b; phase = P_SOF_W1; end
                P_SOF_H1: begin
                    push(jhmp_pkg::K_HEIGHT, 0, 0, 0, {hold, b});
                    phase = P_SOF_W0;
                end
                P_SOF_W1: begin
                    push(jhmp_pkg::K_WIDTH, 0, 0, 0, {hold, b});
                    phase = P_SOF_N;
                end
                P_SOF_N: begin
                    if (b > jhmp_pkg::MaxFrameComponents) error_out(jhmp_pkg::E_COMPS);
                    else if (32'(seg_len) != 8 + 3 * 32'(b)) error_out(jhmp_pkg::E_SOF_LEN);
                    else begin
                        ncomp = b;
                        cnt = '0;
                        phase = (b == 0) ? P_MARK0 : P_SOF_CID;
                    end
                end
                P_SOF_CID: begin cid = b; phase = P_SOF_HV; end
                P_SOF_HV: begin hold = b; phase = P_SOF_TQ; end
                P_SOF_TQ: begin
                    r = '0;
                    r.item_kind = jhmp_pkg::K_FRAMECOMP; r.table_sel = b;
                    r.entry_index = cnt;
                    r.item_value = {8'h00, cid}; r.horiz_samp = hold[7:4];
                    r.vert_samp = hold[3:0];
                    pending.push_back(r);
                    cnt++;
                    phase = (cnt >= ncomp) ? P_MARK0 : P_SOF_CID;
                end
                P_DHT_HDR: begin
                    if (b[7:5] != 0) error_out(jhmp_pkg::E_DHT_BIT);
                    else if (b[3:0] > 3) error_out(jhmp_pkg::E_DHT_ID);
                    else begin
                        cls = b[4];
                        tid = b[3:0];
                        cnt = '0;
                        sym_total = '0;
                        phase = P_DHT_CNT;
                    end
                end
                P_DHT_CNT: begin
                    sym_total = sym_total + 12'(b);
                    if (cnt == 15 && sym_total > jhmp_pkg::MaxHuffSymbols)
                        error_out(jhmp_pkg::E_SYMBOLS);
                    else begin
                        if (cnt == 15)
                            phase = (sym_total == 0) ? past_table(P_DHT_HDR) : P_DHT_SYM;
                        push(jhmp_pkg::K_HUFFCOUNT, cls, {4'h0, tid}, cnt, {8'h00, b});
                        cnt = (cnt == 15) ? 8'd0 : cnt + 8'd1;
                    end
                end
                P_DHT_SYM: begin
                    push(jhmp_pkg::K_HUFFSYM, cls, {4'h0, tid}, cnt, {8'h00, b});
                    cnt++;
                    sym_total--;
                    if (sym_total == 0) phase = past_table(P_DHT_HDR);
                end
                P_SOS_N: begin
                    if (32'(seg_len) != 6 + 2 * 32'(b)) error_out(jhmp_pkg::E_SOS_LEN);
                    else begin
                        cnt = b;
                        phase = (b == 0) ? P_SOS_SS : P_SOS_CID;
                    end
                end
                P_SOS_CID: begin cid = b; phase = P_SOS_TT; end
                P_SOS_TT: begin
                    r = '0;
                    r.item_kind = jhmp_pkg::K_SCANCOMP; r.entry_index = scan_base;
                    r.item_value = {8'h00, cid}; r.dc_table = b[7:4]; r.ac_table = b[3:0];
                    pending.push_back(r);
                    scan_base++;
                    cnt--;
                    phase = (cnt == 0) ? P_SOS_SS : P_SOS_CID;
                end
                P_SOS_SS: begin
                    push(jhmp_pkg::K_SS, 0, 0, 0, {8'h00, b});
                    phase = P_SOS_SE;
                end
                P_SOS_SE: begin
                    push(jhmp_pkg::K_SE, 0, 0, 0, {8'h00, b});
                    phase = P_SOS_A;
                end
                P_SOS_A: begin
                    held_v = 0;
                    phase = P_DATA;
                    push(jhmp_pkg::K_AHAL, 0, 0, 0, {8'h00, b});
                end
                default: begin
                    // entropy data leaves one byte late, ff d9 closes the image
                    if (held_v && held == jhmp_pkg::M_PREFIX && b == jhmp_pkg::M_EOI) begin
                        push(jhmp_pkg::K_END, 0, 0, 0, 0);
                        halted = 1;
                    end else begin
                        if (held_v) push(jhmp_pkg::K_DATA, 0, 0, 0, {8'h00, held});
                        held = b;
                        held_v = 1;
                    end
                end
            endcase
        endfunction

        // compare one result item with the oldest expectation
        function bit check_result(jhmp_pkg::t_result got, output string why);
            jhmp_pkg::t_result exp_r;
            why = "";
            if (pending.size() == 0) begin
                why = $sformatf("unexpected result %h", got);
                return 0;
            end
            exp_r = pending.pop_front();
            n_checked++;
            if (got.item_kind != exp_r.item_kind)
                why = {why, $sformatf(" kind %0d/%0d", got.item_kind, exp_r.item_kind)};
            if (got.table_class != exp_r.table_class)
                why = {why, $sformatf(" class %0d/%0d", got.table_class, exp_r.table_class)};
            if (got.table_sel != exp_r.table_sel)
                why = {why, $sformatf(" sel %0d/%0d", got.table_sel, exp_r.table_sel)};
            if (got.entry_index != exp_r.entry_index)
                why = {why, $sformatf(" index %0d/%0d", got.entry_index, exp_r.entry_index)};
            if (got.item_value != exp_r.item_value)
                why = {why, $sformatf(" value %h/%h", got.item_value, exp_r.item_value)};
            if (got.horiz_samp != exp_r.horiz_samp || got.vert_samp != exp_r.vert_samp)
                why = {why, $sformatf(" hv %h%h/%h%h", got.horiz_samp, got.vert_samp,
                                      exp_r.horiz_samp, exp_r.vert_samp)};
            if (got.dc_table != exp_r.dc_table || got.ac_table != exp_r.ac_table)
                why = {why, $sformatf(" tables %h%h/%h%h", got.dc_table, got.ac_table,
                                      exp_r.dc_table, exp_r.ac_table)};
            if (got.error_code != exp_r.error_code)
                why = {why, $sformatf(" code %0d/%0d", got.error_code, exp_r.error_code)};
            return why == "";
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    jhmp_byte_if   in_if();
    jhmp_result_if out_if();

    jpeg_header_marker_parser i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    marker_scoreboard sb;
    logic [7:0] file_bytes[$];
    int  mismatches;
    int  bytes_sent;
    int  cycles;
    int  rx_wait;
    bit  rx_hold;
    bit  hold_done;

    // clock
    initial i_clk = 0;
    always #2 i_clk = ~i_clk;

    task automatic report(string msg);
        $display("mismatch at cycle %0d:%s", cycles, msg);
        mismatches++;
    endtask

    // stream building
    task automatic put(logic [7:0] b);
        file_bytes.push_back(b);
    endtask

    task automatic seg_head(logic [7:0] mk, int len);
        put(jhmp_pkg::M_PREFIX); put(mk); put(8'(len >> 8)); put(8'(len));
    endtask

    task automatic add_com();
        int n;
        n = $urandom_range(0, 24);
        seg_head(jhmp_pkg::M_COM, n + 2);
        repeat (n) put(8'($urandom));
    endtask

    task automatic add_app0();
        int len;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 8) : 9 + $urandom_range(0, 10);
        seg_head(jhmp_pkg::M_APP0, len);
        for (int i = 0; i < 7; i++) put(sb.sig_byte(8'(i)));
        for (int i = 9; i < len; i++) put(8'($urandom));
    endtask

    task automatic add_dqt();
        int nt;
        int len;
        bit [3:0] pq[2];
        nt = $urandom_range(1, 2);
        len = 2;
        for (int t = 0; t < nt; t++) begin
            pq[t] = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(1, 15)) : 4'd0;
            len += 1 + ((pq[t] != 0) ? 128 : 64);
        end
        // a short length ends the segment after the first table, or makes it empty
        if ($urandom_range(0, 4) == 0) begin
            nt = 1;
            len = $urandom_range(2, 60);
            if (len <= 2) nt = 0;
        end
        seg_head(jhmp_pkg::M_DQT, len);
        for (int t = 0; t < nt; t++) begin
            put({pq[t], 4'($urandom_range(0, 3))});
            repeat ((pq[t] != 0) ? 128 : 64) put(8'($urandom));
        end
    endtask

    task automatic add_dht();
        int nt;
        int len;
        int total;
        logic [7:0] counts[16];
        seg_head(jhmp_pkg::M_DHT, 0);
        len = 2;
        nt = $urandom_range(1, 2);
        for (int t = 0; t < nt; t++) begin
            total = 0;
            for (int i = 0; i < 16; i++) begin
                counts[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'd0;
                total += counts[i];
            end
            put({3'b000, 1'($urandom), 4'($urandom_range(0, 3))});
            for (int i = 0; i < 16; i++) put(counts[i]);
            repeat (total) put(8'($urandom));
            len += 17 + total;
        end
        file_bytes[file_bytes.size() - len] = 8'(len >> 8);
        file_bytes[file_bytes.size() - len + 1] = 8'(len);
    endtask

    task automatic add_sof(int n, logic [15:0] h, logic [15:0] w);
        seg_head(jhmp_pkg::M_SOF0, 8 + 3 * n);
        put(8'd8); put(h[15:8]); put(h[7:0]); put(w[15:8]); put(w[7:0]); put(8'(n));
        repeat (n) begin
            put(8'($urandom)); put(8'($urandom)); put(8'($urandom));
        end
    endtask

    task automatic add_scan_and_data();
        int n;
        int nd;
        logic [7:0] b;
        n = $urandom_range(0, 4);
        seg_head(jhmp_pkg::M_SOS, 6 + 2 * n);
        put(8'(n));
        repeat (n) begin
            put(8'($urandom)); put(8'($urandom));
        end
        put(8'($urandom)); put(8'($urandom)); put(8'($urandom));
        nd = $urandom_range(60, 200);
        repeat (nd) begin
            b = ($urandom_range(0, 9) == 0) ? jhmp_pkg::M_PREFIX : 8'($urandom);
            put(b);
            // stuffed zero, restart marker or another byte after a prefix
            if (b == jhmp_pkg::M_PREFIX)
                case ($urandom_range(0, 2))
                    0: put(8'h00);
                    1: put(8'($urandom_range(8'hD0, 8'hD7)));
                    default: put(8'($urandom_range(8'hDA, 8'hFF)));
                endcase
        end
        put(jhmp_pkg::M_PREFIX); put(jhmp_pkg::M_EOI);
    endtask

    task automatic build_stream();
        put(jhmp_pkg::M_PREFIX); put(jhmp_pkg::M_SOI);
        // empty comment, short app0, frame with no components and extreme sizes
        seg_head(jhmp_pkg::M_COM, 2);
        seg_head(jhmp_pkg::M_APP0, 2);
        for (int i = 0; i < 7; i++) put(sb.sig_byte(8'(i)));
        add_sof(0, 16'hFFFF, 16'h0000);
        while (file_bytes.size() < 700)
            case ($urandom_range(0, 5))
                0: add_com();
                1: add_app0();
                2, 3: add_dqt();
                4: add_dht();
                default: add_sof($urandom_range(1, 3), 16'($urandom), 16'($urandom));
            endcase
        // usually a clean scan, sometimes a broken tail
        if ($urandom_range(0, 4) != 0) add_scan_and_data();
        else repeat (30) put(($urandom_range(0, 3) == 0) ? jhmp_pkg::M_PREFIX : 8'($urandom));
        repeat (8) put(8'($urandom));
    endtask

    // byte sender
    task automatic send_byte(logic [7:0] b, int gap);
        repeat (gap) begin
            in_if.valid = 0;
            @(negedge i_clk);
        end
        in_if.valid = 1;
        in_if.data_byte = b;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    task automatic send_stream();
        int gap;
        foreach (file_bytes[i]) begin
            gap = ((i / 100) % 3 == 0) ? 0 : $urandom_range(0, 14);
            if (i == 200) begin
                in_if.valid = 0;
                while (sb.pending.size() != 0) @(negedge i_clk);
            end
            send_byte(file_bytes[i], gap);
            bytes_sent++;
        end
        in_if.valid = 0;
    endtask

    // input monitor feeds the predictor
    always @(posedge i_clk)
        if (i_rst_n && in_if.valid && in_if.ready) sb.note_byte(in_if.data_byte);

    // result checker and receiver stall draw
    always @(posedge i_clk) begin
        string why;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (!sb.check_result(out_if.payload, why)) report(why);
            rx_wait = ((cycles / 300) % 3 == 0) ? 0 : $urandom_range(0, 14);
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold) out_if.ready = 0;
        else if (rx_wait > 0) begin
            out_if.ready = 0;
            rx_wait--;
        end else out_if.ready = 1;
    end

    // long receiver hold while bytes keep coming
    initial begin
        rx_hold = 0;
        hold_done = 0;
        wait (bytes_sent >= 400);
        rx_hold = 1;
        repeat (HoldCycles) @(negedge i_clk);
        rx_hold = 0;
        hold_done = 1;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("timeout with %0d results outstanding", sb.pending.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        sb = new();
        mismatches = 0;
        bytes_sent = 0;
        cycles = 0;
        rx_wait = 0;
        in_if.valid = 0;
        in_if.data_byte = '0;
        out_if.ready = 0;
        i_rst_n = 0;
        build_stream();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;
        send_stream();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("sent %0d bytes, checked %0d result items, parser %s at the end",
                 bytes_sent, sb.n_checked, sb.halted ? "halted" : "still running");
        if (mismatches == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
